// ===== rtl/plic_pkg.sv =====
// shared constants, command/status structs and controller state type for the
// piecewise linear interpolator; no dependencies
`default_nettype none

package plic_pkg;

  localparam int VALUE_W        = 32;
  localparam int IDX_W          = 6;
  localparam int CNT_W          = 7;
  localparam int PROD_W         = 2 * VALUE_W;
  localparam int SAT_SHIFT      = 40;
  localparam int SUM_W          = SAT_SHIFT + 3;
  localparam int S_DATA_W       = ((IDX_W + 2 * VALUE_W + 7) / 8) * 8;
  localparam int S_USER_W       = 1;
  localparam int M_DATA_W       = VALUE_W;
  localparam int M_USER_W       = 2;
  localparam int DEF_MAX_POINTS = 64;
  localparam int DIV_CNT_W      = $clog2(PROD_W + 1);

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_LOAD0,
    ST_SCAN,
    ST_MULT,
    ST_DIV,
    ST_FINAL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic mem_write;
    logic res_clear;
    logic res_first_y;
    logic rd_first;
    logic rd_next;
    logic prev_load;
    logic seg_take;
    logic res_span;
    logic mult;
    logic div_step;
    logic res_final;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic n_zero;
    logic n_one;
    logic seg_hit;
    logic span_zero;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/plic_ctrl.sv =====
// controller state machine: sequences table writes, segment scan, divide and
// result hand-off; depends on plic_pkg
`default_nettype none

module plic_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  output logic            m_tvalid,
  input  logic            m_tready,
  input  plic_pkg::stat_t stat,
  output plic_pkg::cmd_t  cmd
);
  import plic_pkg::*;

  state_t                 state, state_next;
  logic                   out_valid, out_valid_next;
  logic [DIV_CNT_W-1:0]   div_cnt, div_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      div_cnt   <= '0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      div_cnt   <= div_cnt_next;
    end
  end

  always_comb begin
    state_next   = state;
    div_cnt_next = div_cnt;
    cmd          = '0;
    s_tready     = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (!stat.is_query) begin
          cmd.mem_write = 1'b1;
          cmd.res_clear = 1'b1;
          state_next    = ST_DONE;
        end else if (stat.n_zero) begin
          cmd.res_clear = 1'b1;
          state_next    = ST_DONE;
        end else begin
          cmd.rd_first = 1'b1;
          state_next   = ST_LOAD0;
        end
      end
      ST_LOAD0: begin
        if (stat.n_one) begin
          cmd.res_first_y = 1'b1;
          state_next      = ST_DONE;
        end else begin
          cmd.prev_load = 1'b1;
          cmd.rd_next   = 1'b1;
          state_next    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.seg_hit) begin
          cmd.seg_take = 1'b1;
          state_next   = ST_MULT;
        end else begin
          cmd.prev_load = 1'b1;
          cmd.rd_next   = 1'b1;
        end
      end
      ST_MULT: begin
        if (stat.span_zero) begin
          cmd.res_span = 1'b1;
          state_next   = ST_DONE;
        end else begin
          cmd.mult     = 1'b1;
          div_cnt_next = DIV_CNT_W'(PROD_W);
          state_next   = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt - 1'b1;
        if (div_cnt == DIV_CNT_W'(1)) begin
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: begin
        cmd.res_final = 1'b1;
        state_next    = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || m_tready) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    out_valid_next = cmd.publish | (out_valid & ~m_tready);
  end

  assign m_tvalid = out_valid;

endmodule

`default_nettype wire

// ===== rtl/plic_dpath.sv =====
// datapath: breakpoint memory, segment registers, multiplier, restoring
// divider, saturation and output register; depends on plic_pkg
`default_nettype none

module plic_dpath #(
  parameter int MAX_POINTS = plic_pkg::DEF_MAX_POINTS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [plic_pkg::S_DATA_W-1:0] s_tdata,
  input  logic [plic_pkg::S_USER_W-1:0] s_tuser,
  input  logic                          cfg_wen,
  input  logic [plic_pkg::CNT_W-1:0]    cfg_wdata,
  input  plic_pkg::cmd_t                cmd,
  output plic_pkg::stat_t               stat,
  output logic [plic_pkg::M_DATA_W-1:0] m_tdata,
  output logic [plic_pkg::M_USER_W-1:0] m_tuser
);
  import plic_pkg::*;

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;

  localparam logic [VALUE_W-1:0] MAX_V = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] MIN_V = {1'b1, {(VALUE_W-1){1'b0}}};

  function automatic logic [VALUE_W-1:0] mag(input logic [VALUE_W:0] v);
    logic [VALUE_W:0] a;
    a = v[VALUE_W] ? (~v + 1'b1) : v;
    return a[VALUE_W-1:0];
  endfunction

  logic [CNT_W-1:0]           point_count;
  logic                       cap_type;
  logic [IDX_W-1:0]           cap_index;
  logic signed [VALUE_W-1:0]  cap_x, cap_y;

  logic [2*VALUE_W-1:0]       mem [MAX_POINTS];
  logic [2*VALUE_W-1:0]       rdata;
  logic [AW-1:0]              rd_idx, rd_addr, wr_addr;
  logic [CW-1:0]              idx_wide, pc_wide, n;
  logic                       wr_ok;
  logic signed [VALUE_W-1:0]  rd_x, rd_y, prev_x, prev_y;

  logic [VALUE_W:0]           dq_c, dy_c, dx_c;
  logic [VALUE_W-1:0]         y0, dq_mag, dy_mag, dx_mag;
  logic                       neg;

  logic [VALUE_W-1:0]         rem;
  logic [PROD_W-1:0]          quo;
  logic [VALUE_W:0]           rem_sh, rem_sub;
  logic                       rem_ge;

  logic                       big, ovf;
  logic [SUM_W-1:0]           y0e, me, sum;
  logic [SUM_W-VALUE_W:0]     sum_top;
  logic [VALUE_W-1:0]         fin_y;

  logic [VALUE_W-1:0]         res_y;
  logic                       res_zs, res_sat;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
    end else if (cfg_wen) begin
      point_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_type  <= s_tuser[0];
      cap_index <= s_tdata[IDX_W-1:0];
      cap_x     <= s_tdata[IDX_W+VALUE_W-1:IDX_W];
      cap_y     <= s_tdata[IDX_W+2*VALUE_W-1:IDX_W+VALUE_W];
    end
  end

  assign idx_wide = CW'(cap_index);
  assign wr_ok    = idx_wide < CW'(MAX_POINTS);
  assign wr_addr  = idx_wide[AW-1:0];
  assign rd_addr  = cmd.rd_first ? '0 : rd_idx + 1'b1;

  // breakpoint table, entry is {x, y}
  always_ff @(posedge clk) begin
    if (cmd.mem_write && wr_ok) begin
      mem[wr_addr] <= {cap_x, cap_y};
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_first || cmd.rd_next) begin
      rd_idx <= rd_addr;
    end
    if (cmd.prev_load) begin
      prev_x <= rd_x;
      prev_y <= rd_y;
    end
  end

  assign rd_x    = rdata[2*VALUE_W-1:VALUE_W];
  assign rd_y    = rdata[VALUE_W-1:0];
  assign pc_wide = CW'(point_count);
  assign n       = (pc_wide > CW'(MAX_POINTS)) ? CW'(MAX_POINTS) : pc_wide;

  assign dq_c = {cap_x[VALUE_W-1], cap_x} - {prev_x[VALUE_W-1], prev_x};
  assign dy_c = {rd_y[VALUE_W-1], rd_y} - {prev_y[VALUE_W-1], prev_y};
  assign dx_c = {rd_x[VALUE_W-1], rd_x} - {prev_x[VALUE_W-1], prev_x};

  always_ff @(posedge clk) begin
    if (cmd.seg_take) begin
      y0     <= prev_y;
      dq_mag <= mag(dq_c);
      dy_mag <= mag(dy_c);
      dx_mag <= mag(dx_c);
      neg    <= dq_c[VALUE_W] ^ dy_c[VALUE_W] ^ dx_c[VALUE_W];
    end
  end

  // restoring divide, one quotient bit per step, dividend shifts out of quo
  assign rem_sh  = {rem, quo[PROD_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, dx_mag};
  assign rem_sub = rem_sh - {1'b0, dx_mag};

  always_ff @(posedge clk) begin
    if (cmd.mult) begin
      quo <= PROD_W'(dq_mag) * PROD_W'(dy_mag);
      rem <= '0;
    end else if (cmd.div_step) begin
      quo <= {quo[PROD_W-2:0], rem_ge};
      rem <= rem_ge ? rem_sub[VALUE_W-1:0] : rem_sh[VALUE_W-1:0];
    end
  end

  // add to or subtract from y0 and clip
  assign big     = (|quo[PROD_W-1:SAT_SHIFT+1]) | (quo[SAT_SHIFT] & (|quo[SAT_SHIFT-1:0]));
  assign y0e     = {{(SUM_W-VALUE_W){y0[VALUE_W-1]}}, y0};
  assign me      = {2'b00, quo[SAT_SHIFT:0]};
  assign sum     = neg ? (y0e - me) : (y0e + me);
  assign sum_top = sum[SUM_W-1:VALUE_W-1];
  assign ovf     = !((&sum_top) || (~|sum_top));

  always_comb begin
    if (big) begin
      fin_y = neg ? MIN_V : MAX_V;
    end else if (ovf) begin
      fin_y = sum[SUM_W-1] ? MIN_V : MAX_V;
    end else begin
      fin_y = sum[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_clear) begin
      res_y   <= '0;
      res_zs  <= 1'b0;
      res_sat <= 1'b0;
    end else if (cmd.res_first_y) begin
      res_y   <= rd_y;
      res_zs  <= 1'b0;
      res_sat <= 1'b0;
    end else if (cmd.res_span) begin
      res_y   <= y0;
      res_zs  <= 1'b1;
      res_sat <= 1'b0;
    end else if (cmd.res_final) begin
      res_y   <= fin_y;
      res_zs  <= 1'b0;
      res_sat <= big | ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      m_tdata <= res_y;
      m_tuser <= {res_sat, res_zs};
    end
  end

  assign stat.is_query  = (cap_type == REQ_QUERY);
  assign stat.n_zero    = (n == '0);
  assign stat.n_one     = (n == CW'(1));
  assign stat.seg_hit   = (cap_x < rd_x) || (CW'(rd_idx) == n - CW'(1));
  assign stat.span_zero = (dx_mag == '0);

endmodule

`default_nettype wire

// ===== rtl/piecewise_linear_interpolator_unit.sv =====
// top level of the piecewise linear interpolator: controller plus datapath
// depends on plic_pkg, plic_ctrl, plic_dpath
//
// channel   dir  handshake            payload
// s_*       in   s_tvalid/s_tready    tdata {y_value, x_value, point_index}, tuser req_type
// m_*       out  m_tvalid/m_tready    tdata y_result, tuser {saturated, zero_span}
// cfg_*     in   cfg_wen (no stall)   cfg_wdata point_count
//
// a table write passes DISPATCH and DONE and leaves a cleared result in the output register
// a query on two or more breakpoints passes DISPATCH, LOAD0, SCAN, MULT, DIV, FINAL, DONE:
// the scan reads one table entry a cycle, then the divider retires one quotient bit a cycle;
// a zero-width segment skips the divide
// one item is in work at a time; the block waits only if the output register is still
// full when the next result is ready; reset clears point_count and the handshake state
`default_nettype none

module piecewise_linear_interpolator_unit #(
  parameter int MAX_POINTS = plic_pkg::DEF_MAX_POINTS
) (
  input  logic                          clk,
  input  logic                          rst,
  // lowest bit up: point_index[5:0], x_value[37:6], y_value[69:38], zero pad
  input  logic [plic_pkg::S_DATA_W-1:0] s_tdata,
  // req_type[0]
  input  logic [plic_pkg::S_USER_W-1:0] s_tuser,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // y_result[31:0]
  output logic [plic_pkg::M_DATA_W-1:0] m_tdata,
  // zero_span[0], saturated[1]
  output logic [plic_pkg::M_USER_W-1:0] m_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic                          cfg_wen,
  input  logic [plic_pkg::CNT_W-1:0]    cfg_wdata
);
  import plic_pkg::*;

  cmd_t  cmd;   // controller to datapath
  stat_t stat;  // datapath to controller

  // sequencing and handshake
  plic_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // table, arithmetic and output register
  plic_dpath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

`default_nettype wire

// ===== rtl/plic_checker.sv =====
// port-level checks for the interpolator, bound onto the top level
// depends on plic_pkg and piecewise_linear_interpolator_unit
`default_nettype none

module plic_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [plic_pkg::M_DATA_W-1:0] m_tdata,
  input logic [plic_pkg::M_USER_W-1:0] m_tuser
);

  // one item at a time: the input side closes after every transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while an item is in work");

  // a zero-width segment never reports clipping
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("zero_span and saturated both set");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("result withdrawn before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

endmodule

bind piecewise_linear_interpolator_unit plic_checker u_plic_checker (.*);

`default_nettype wire
